// ----- hdl/assert_macros.svh -----
// Assertion helpers shared by the queue and back-end modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NTI_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define NTI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- hdl/nti_pkg.sv -----
package nti_pkg;

  localparam int FRAC_BITS_DEF   = 16;
  localparam int COUNT_BITS_DEF  = 16;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int LEN_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_LEN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_LEN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPLIT_MODE = 2'd3;

  localparam logic [LEN_W-1:0] ROW_COUNT_RST  = 16'd1;
  localparam logic [LEN_W-1:0] FIRST_LEN_RST  = 16'd2;
  localparam logic [LEN_W-1:0] SECOND_LEN_RST = 16'd2;

  typedef struct packed {
    logic signed [31:0] integrand;
    logic signed [31:0] inner_coord;
    logic signed [31:0] outer_coord;
  } in_t;

  typedef struct packed {
    logic signed [63:0] integral;
    logic               saturated;
  } out_t;

  typedef struct packed {
    logic [LEN_W-1:0] row_count;
    logic [LEN_W-1:0] first_segment_len;
    logic [LEN_W-1:0] second_segment_len;
    logic             split_mode;
  } cfg_t;

  typedef struct packed {
    logic inner_en;   // sample closes an inner trapezoid
    logic row_start;  // sample latches the row's outer coordinate
    logic row_end;    // sample closes the row
    logic outer_en;   // row end adds an outer trapezoid
    logic last;       // row end closes the integration
  } flags_t;

  typedef struct packed {
    in_t    data;
    flags_t flags;
  } q_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ISUM,
    ST_OPND,
    ST_OMUL,
    ST_OADD,
    ST_OSAT,
    ST_FIN
  } back_state_t;

endpackage

// ----- hdl/nti_front.sv -----
module nti_front #(
  parameter int COUNT_BITS = nti_pkg::COUNT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  nti_pkg::in_t      in_data,
  input  nti_pkg::cfg_t     cfg,
  input  logic              q_full,
  output logic              q_push,
  output nti_pkg::q_item_t  q_item
);

  localparam int CW = (COUNT_BITS > nti_pkg::LEN_W ? COUNT_BITS : nti_pkg::LEN_W) + 1;

  logic [COUNT_BITS-1:0] sample_idx_r, sample_idx_nxt;
  logic [COUNT_BITS-1:0] row_idx_r, row_idx_nxt;
  logic                  seg_sel_r, seg_sel_nxt;

  logic                       accept;
  logic [nti_pkg::LEN_W-1:0]  seg_len;
  logic [CW-1:0]              seg_len_eff;
  logic [CW-1:0]              row_cnt_eff;
  logic                       seg_end;
  logic                       row_at_end;
  nti_pkg::flags_t            flags;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept;

  always_comb begin
    seg_len     = seg_sel_r ? cfg.second_segment_len : cfg.first_segment_len;
    // a length of zero acts as one
    seg_len_eff = (seg_len == '0) ? CW'(1) : {{(CW-nti_pkg::LEN_W){1'b0}}, seg_len};
    row_cnt_eff = (cfg.row_count == '0) ? CW'(1)
                                        : {{(CW-nti_pkg::LEN_W){1'b0}}, cfg.row_count};
    seg_end     = ({{(CW-COUNT_BITS){1'b0}}, sample_idx_r} + CW'(1) >= seg_len_eff) ||
                  (&sample_idx_r);
    row_at_end  = ({{(CW-COUNT_BITS){1'b0}}, row_idx_r} + CW'(1) >= row_cnt_eff) ||
                  (&row_idx_r);

    flags.inner_en  = (sample_idx_r != '0);
    flags.row_start = (sample_idx_r == '0) && !seg_sel_r;
    flags.row_end   = seg_end && !(!seg_sel_r && cfg.split_mode);
    flags.outer_en  = (row_idx_r != '0);
    flags.last      = flags.row_end && row_at_end;

    q_item.data  = in_data;
    q_item.flags = flags;

    sample_idx_nxt = sample_idx_r;
    row_idx_nxt    = row_idx_r;
    seg_sel_nxt    = seg_sel_r;
    if (accept) begin
      if (!seg_end) begin
        sample_idx_nxt = sample_idx_r + COUNT_BITS'(1);
      end else begin
        sample_idx_nxt = '0;
        seg_sel_nxt    = !seg_sel_r && cfg.split_mode;
        if (flags.row_end) begin
          row_idx_nxt = flags.last ? '0 : row_idx_r + COUNT_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_idx_r <= '0;
      row_idx_r    <= '0;
      seg_sel_r    <= 1'b0;
    end else begin
      sample_idx_r <= sample_idx_nxt;
      row_idx_r    <= row_idx_nxt;
      seg_sel_r    <= seg_sel_nxt;
    end
  end

endmodule

// ----- hdl/nti_queue.sv -----
`include "assert_macros.svh"

module nti_queue #(
  parameter int DEPTH = nti_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  nti_pkg::q_item_t  wr_item,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output nti_pkg::q_item_t  rd_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  nti_pkg::q_item_t  mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_push, do_pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign rd_item   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

  `NTI_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(DEPTH))
  `NTI_ASSERT_NEXT(a_push_count, clk, rst_n, do_push && !do_pop, count_r != '0)

endmodule

// ----- hdl/nti_back.sv -----
`include "assert_macros.svh"

module nti_back #(
  parameter int FRAC_BITS = nti_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  nti_pkg::q_item_t  q_item,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output nti_pkg::out_t     out_data
);

  localparam int SHIFT = FRAC_BITS + 1;
  localparam logic signed [47:0] MAX48 = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] MIN48 = {1'b1, {47{1'b0}}};
  localparam logic signed [63:0] MAX64 = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] MIN64 = {1'b1, {63{1'b0}}};

  nti_pkg::back_state_t state_r, state_nxt;

  // accumulator state
  logic signed [31:0] last_f_r, last_f_nxt;
  logic signed [31:0] last_x_r, last_x_nxt;
  logic signed [31:0] row_outer_r, row_outer_nxt;
  logic signed [31:0] prev_outer_r, prev_outer_nxt;
  logic signed [47:0] row_sum_r, row_sum_nxt;
  logic signed [47:0] prev_sum_r, prev_sum_nxt;
  logic signed [63:0] total_r, total_nxt;
  logic               ovf_r, ovf_nxt;
  logic               out_valid_r, out_valid_nxt;

  // datapath stages
  nti_pkg::flags_t    flg_r, flg_nxt;
  logic signed [32:0] sa_r, sa_nxt;
  logic signed [32:0] sb_r, sb_nxt;
  logic signed [65:0] prod_r, prod_nxt;
  logic signed [48:0] oa_r, oa_nxt;
  logic signed [32:0] ob_r, ob_nxt;
  logic signed [65:0] plo_r, plo_nxt;
  logic signed [49:0] phi_r, phi_nxt;
  logic signed [81:0] osh_r, osh_nxt;
  logic signed [63:0] oterm_r, oterm_nxt;
  logic               oterm_ovf_r, oterm_ovf_nxt;
  nti_pkg::out_t      out_data_r, out_data_nxt;

  logic signed [65:0] ish;
  logic               ish_fits;
  logic signed [47:0] iterm;
  logic signed [48:0] isum;
  logic               isum_fits;
  logic               osh_fits;
  logic signed [64:0] tsum;
  logic               tsum_fits;
  logic signed [63:0] total_new;
  logic               ovf_new;
  logic               fin_go;
  logic               at_fin;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign at_fin    = (state_r == nti_pkg::ST_FIN);

  always_comb begin
    state_nxt      = state_r;
    last_f_nxt     = last_f_r;
    last_x_nxt     = last_x_r;
    row_outer_nxt  = row_outer_r;
    prev_outer_nxt = prev_outer_r;
    row_sum_nxt    = row_sum_r;
    prev_sum_nxt   = prev_sum_r;
    total_nxt      = total_r;
    ovf_nxt        = ovf_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    flg_nxt        = flg_r;
    sa_nxt         = sa_r;
    sb_nxt         = sb_r;
    prod_nxt       = prod_r;
    oa_nxt         = oa_r;
    ob_nxt         = ob_r;
    plo_nxt        = plo_r;
    phi_nxt        = phi_r;
    osh_nxt        = osh_r;
    oterm_nxt      = oterm_r;
    oterm_ovf_nxt  = oterm_ovf_r;
    out_data_nxt   = out_data_r;
    q_pop          = 1'b0;

    // inner term: floor shift, then clamp to 48 bits
    ish       = prod_r >>> SHIFT;
    ish_fits  = (&ish[65:47]) || !(|ish[65:47]);
    iterm     = ish_fits ? ish[47:0] : (ish[65] ? MIN48 : MAX48);
    isum      = 49'(row_sum_r) + 49'(iterm);
    isum_fits = (isum[48] == isum[47]);

    osh_fits  = (&osh_r[81:63]) || !(|osh_r[81:63]);

    tsum      = 65'(total_r) + 65'(oterm_r);
    tsum_fits = (tsum[64] == tsum[63]);
    if (!flg_r.outer_en) begin
      total_new = total_r;
      ovf_new   = ovf_r;
    end else begin
      total_new = tsum_fits ? tsum[63:0] : (tsum[64] ? MIN64 : MAX64);
      ovf_new   = ovf_r || oterm_ovf_r || !tsum_fits;
    end
    // hold the final row end until the output register is free
    fin_go = !(flg_r.last && out_valid_r && !out_ready);

    case (state_r)
      nti_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          flg_nxt    = q_item.flags;
          sa_nxt     = 33'(q_item.data.integrand) + 33'(last_f_r);
          sb_nxt     = 33'(q_item.data.inner_coord) - 33'(last_x_r);
          last_f_nxt = q_item.data.integrand;
          last_x_nxt = q_item.data.inner_coord;
          if (q_item.flags.row_start) begin
            row_outer_nxt = q_item.data.outer_coord;
          end
          state_nxt = nti_pkg::ST_MUL;
        end
      end
      nti_pkg::ST_MUL: begin
        prod_nxt  = 66'(sa_r) * 66'(sb_r);
        state_nxt = nti_pkg::ST_ISUM;
      end
      nti_pkg::ST_ISUM: begin
        if (flg_r.inner_en) begin
          row_sum_nxt = isum_fits ? isum[47:0] : (isum[48] ? MIN48 : MAX48);
          ovf_nxt     = ovf_r || !ish_fits || !isum_fits;
        end
        if (!flg_r.row_end) begin
          state_nxt = nti_pkg::ST_IDLE;
        end else if (flg_r.outer_en) begin
          state_nxt = nti_pkg::ST_OPND;
        end else begin
          state_nxt = nti_pkg::ST_FIN;
        end
      end
      nti_pkg::ST_OPND: begin
        oa_nxt    = 49'(row_sum_r) + 49'(prev_sum_r);
        ob_nxt    = 33'(row_outer_r) - 33'(prev_outer_r);
        state_nxt = nti_pkg::ST_OMUL;
      end
      nti_pkg::ST_OMUL: begin
        // split the 49-bit operand into a low unsigned and a high signed part
        plo_nxt   = 66'($signed({1'b0, oa_r[31:0]})) * 66'(ob_r);
        phi_nxt   = 50'($signed(oa_r[48:32])) * 50'(ob_r);
        state_nxt = nti_pkg::ST_OADD;
      end
      nti_pkg::ST_OADD: begin
        osh_nxt   = ((82'(phi_r) <<< 32) + 82'(plo_r)) >>> SHIFT;
        state_nxt = nti_pkg::ST_OSAT;
      end
      nti_pkg::ST_OSAT: begin
        oterm_nxt     = osh_fits ? osh_r[63:0] : (osh_r[81] ? MIN64 : MAX64);
        oterm_ovf_nxt = !osh_fits;
        state_nxt     = nti_pkg::ST_FIN;
      end
      nti_pkg::ST_FIN: begin
        if (fin_go) begin
          state_nxt = nti_pkg::ST_IDLE;
          if (flg_r.last) begin
            out_valid_nxt         = 1'b1;
            out_data_nxt.integral = total_new;
            out_data_nxt.saturated = ovf_new;
            last_f_nxt     = '0;
            last_x_nxt     = '0;
            row_outer_nxt  = '0;
            prev_outer_nxt = '0;
            row_sum_nxt    = '0;
            prev_sum_nxt   = '0;
            total_nxt      = '0;
            ovf_nxt        = 1'b0;
          end else begin
            total_nxt      = total_new;
            ovf_nxt        = ovf_new;
            prev_sum_nxt   = row_sum_r;
            prev_outer_nxt = row_outer_r;
            row_sum_nxt    = '0;
          end
        end
      end
      default: begin
        state_nxt = nti_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= nti_pkg::ST_IDLE;
      last_f_r     <= '0;
      last_x_r     <= '0;
      row_outer_r  <= '0;
      prev_outer_r <= '0;
      row_sum_r    <= '0;
      prev_sum_r   <= '0;
      total_r      <= '0;
      ovf_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      last_f_r     <= last_f_nxt;
      last_x_r     <= last_x_nxt;
      row_outer_r  <= row_outer_nxt;
      prev_outer_r <= prev_outer_nxt;
      row_sum_r    <= row_sum_nxt;
      prev_sum_r   <= prev_sum_nxt;
      total_r      <= total_nxt;
      ovf_r        <= ovf_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    flg_r       <= flg_nxt;
    sa_r        <= sa_nxt;
    sb_r        <= sb_nxt;
    prod_r      <= prod_nxt;
    oa_r        <= oa_nxt;
    ob_r        <= ob_nxt;
    plo_r       <= plo_nxt;
    phi_r       <= phi_nxt;
    osh_r       <= osh_nxt;
    oterm_r     <= oterm_nxt;
    oterm_ovf_r <= oterm_ovf_nxt;
    out_data_r  <= out_data_nxt;
  end

  `NTI_ASSERT_SAME(a_pop_idle, clk, rst_n, q_pop, state_r == nti_pkg::ST_IDLE)
  `NTI_ASSERT_NEXT(a_emit, clk, rst_n, at_fin && flg_r.last && fin_go, out_valid_r)
  `NTI_ASSERT_NEXT(a_fin_hold, clk, rst_n, at_fin && !fin_go, at_fin)

endmodule

// ----- hdl/nested_trapezoid_integrator_top.sv -----
// Per sample the back end steps through load, multiply and accumulate, and pops the next sample only
// once back in its idle state. A row end then passes through a finish step, and through operand,
// split multiply, add and saturate steps before it when an outer trapezoid is added.
// Up to QUEUE_DEPTH samples queue ahead of the back end, so input keeps flowing meanwhile.
// Reset (rst_n low, synchronous) clears all sums, counters and queues; registers return to
// row_count 1, first_segment_len 2, second_segment_len 2, split_mode 0.
module nested_trapezoid_integrator_top #(
  parameter int FRAC_BITS   = nti_pkg::FRAC_BITS_DEF,
  parameter int COUNT_BITS  = nti_pkg::COUNT_BITS_DEF,
  parameter int QUEUE_DEPTH = nti_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  nti_pkg::in_t                    in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output nti_pkg::out_t                   out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [nti_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [nti_pkg::LEN_W-1:0]       cfg_data
);

  nti_pkg::cfg_t    cfg_r, cfg_nxt;
  logic             q_full, q_push, q_pop, q_valid;
  nti_pkg::q_item_t q_wr_item, q_rd_item;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        nti_pkg::REG_ROW_COUNT:  cfg_nxt.row_count          = cfg_data;
        nti_pkg::REG_FIRST_LEN:  cfg_nxt.first_segment_len  = cfg_data;
        nti_pkg::REG_SECOND_LEN: cfg_nxt.second_segment_len = cfg_data;
        nti_pkg::REG_SPLIT_MODE: cfg_nxt.split_mode         = cfg_data[0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.row_count          <= nti_pkg::ROW_COUNT_RST;
      cfg_r.first_segment_len  <= nti_pkg::FIRST_LEN_RST;
      cfg_r.second_segment_len <= nti_pkg::SECOND_LEN_RST;
      cfg_r.split_mode         <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  nti_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cfg      (cfg_r),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_wr_item)
  );

  nti_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wr_item   (q_wr_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .rd_item   (q_rd_item)
  );

  nti_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_rd_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import nti_pkg::*;

  localparam int DRAIN_CYCLES = 64;
  localparam int STALL_LIMIT  = 4000;
  localparam int RANDOM_ITEMS = 1450;

  localparam logic signed [127:0] Q64_MAX = 128'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [127:0] Q64_MIN = -Q64_MAX - 128'sd1;
  localparam logic signed [63:0]  Q48_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0]  Q48_MIN = -Q48_MAX - 64'sd1;
  localparam logic [31:0]         W_MAX   = 32'h7FFF_FFFF;
  localparam logic [31:0]         W_MIN   = 32'h8000_0000;
  localparam logic [31:0]         ONE     = 32'h0001_0000;
  localparam logic [15:0]         CNT_TOP = 16'hFFFF;

  typedef enum bit {DIR_CFG, DIR_SAMPLE} dir_kind_e;

  typedef struct packed {
    dir_kind_e            kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [LEN_W-1:0]     reg_val;
    in_t                  smp;
    bit                   typed;
    out_t                 want;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  in_t                  in_data;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_t                 out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [LEN_W-1:0]     cfg_data;

  nested_trapezoid_integrator_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Integrator model: settings and running sums
  logic [15:0]        rows_cfg, len1_cfg, len2_cfg;
  logic               split_cfg;
  logic signed [63:0] prev_f, prev_x, row_sum, prior_row_sum;
  logic signed [63:0] prior_outer, row_outer, total;
  logic [15:0]        smp_idx, row_idx;
  logic               in_second;
  logic               sat_seen;

  out_t     expected_totals[$];
  out_t     head_total;
  dir_row_t dir_rows[$];
  int       in_idle_pct;
  int       out_stall_pct;
  int       mismatches = 0;
  int       idle_cycles = 0;

  function automatic void clear_integration();
    prev_f        = '0;
    prev_x        = '0;
    row_sum       = '0;
    prior_row_sum = '0;
    prior_outer   = '0;
    row_outer     = '0;
    total         = '0;
    smp_idx       = '0;
    row_idx       = '0;
    in_second     = 1'b0;
    sat_seen      = 1'b0;
  endfunction

  function automatic void reset_integrator();
    rows_cfg  = ROW_COUNT_RST;
    len1_cfg  = FIRST_LEN_RST;
    len2_cfg  = SECOND_LEN_RST;
    split_cfg = 1'b0;
    clear_integration();
  endfunction

  // Exact product, halved and scaled with floor, clamped to 64 bits
  function automatic logic signed [63:0] fix_mul(logic signed [127:0] a,
                                                 logic signed [127:0] b);
    logic signed [127:0] q;
    q = (a * b) >>> (FRAC_BITS_DEF + 1);
    if (q > Q64_MAX) begin
      sat_seen = 1'b1;
      return Q64_MAX[63:0];
    end
    if (q < Q64_MIN) begin
      sat_seen = 1'b1;
      return Q64_MIN[63:0];
    end
    return q[63:0];
  endfunction

  function automatic logic signed [63:0] clamp48(logic signed [63:0] v);
    if (v > Q48_MAX) begin
      sat_seen = 1'b1;
      return Q48_MAX;
    end
    if (v < Q48_MIN) begin
      sat_seen = 1'b1;
      return Q48_MIN;
    end
    return v;
  endfunction

  function automatic logic signed [63:0] sat_add64(logic signed [63:0] a,
                                                   logic signed [63:0] b);
    logic signed [127:0] s;
    s = a + b;
    if (s > Q64_MAX) begin
      sat_seen = 1'b1;
      return Q64_MAX[63:0];
    end
    if (s < Q64_MIN) begin
      sat_seen = 1'b1;
      return Q64_MIN[63:0];
    end
    return s[63:0];
  endfunction

  // A zero length acts as one; a counter at its top also ends the count
  function automatic bit count_done(logic [15:0] idx, logic [15:0] len);
    logic [16:0] lim;
    lim = (len == 16'd0) ? 17'd1 : {1'b0, len};
    return ({1'b0, idx} + 17'd1 >= lim) || (idx == CNT_TOP);
  endfunction

  function automatic bit integrate_sample(in_t s, output out_t res);
    logic signed [63:0] f, x, term;
    logic [15:0]        len;
    f   = {{32{s.integrand[31]}}, s.integrand};
    x   = {{32{s.inner_coord[31]}}, s.inner_coord};
    res = '0;
    len = in_second ? len2_cfg : len1_cfg;
    if (smp_idx == 16'd0 && !in_second)
      row_outer = {{32{s.outer_coord[31]}}, s.outer_coord};
    if (smp_idx != 16'd0) begin
      term    = clamp48(fix_mul(f + prev_f, x - prev_x));
      row_sum = clamp48(row_sum + term);
    end
    prev_f = f;
    prev_x = x;
    if (!count_done(smp_idx, len)) begin
      smp_idx = smp_idx + 16'd1;
      return 1'b0;
    end
    smp_idx = '0;
    if (!in_second && split_cfg) begin
      in_second = 1'b1;
      return 1'b0;
    end
    in_second = 1'b0;
    if (row_idx != 16'd0)
      total = sat_add64(total, fix_mul(row_sum + prior_row_sum, row_outer - prior_outer));
    prior_row_sum = row_sum;
    prior_outer   = row_outer;
    row_sum       = '0;
    if (count_done(row_idx, rows_cfg)) begin
      res.integral  = total;
      res.saturated = sat_seen;
      clear_integration();
      return 1'b1;
    end
    row_idx = row_idx + 16'd1;
    return 1'b0;
  endfunction

  function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [LEN_W-1:0] val);
    dir_row_t r;
    r         = '0;
    r.kind    = DIR_CFG;
    r.reg_idx = idx;
    r.reg_val = val;
    dir_rows.push_back(r);
  endfunction

  function automatic void add_smp(logic [31:0] f, logic [31:0] x, logic [31:0] d,
                                  bit typed = 1'b0, logic [63:0] total_want = '0,
                                  bit sat_want = 1'b0);
    dir_row_t r;
    r                  = '0;
    r.kind             = DIR_SAMPLE;
    r.smp.integrand    = f;
    r.smp.inner_coord  = x;
    r.smp.outer_coord  = d;
    r.typed            = typed;
    r.want.integral    = total_want;
    r.want.saturated   = sat_want;
    dir_rows.push_back(r);
  endfunction

  function automatic void build_directed();
    // a single-row integration has no outer trapezoid, so its total is zero
    add_smp(ONE, 32'h0, 32'h0);
    add_smp(ONE, ONE, 32'h0, 1'b1, 64'd0, 1'b0);
    add_cfg(REG_ROW_COUNT, 16'd3);
    add_smp(ONE, 32'h0, 32'h0);
    add_smp(ONE, ONE, 32'h1234_5678);
    add_smp(2 * ONE, 32'h0, ONE);
    add_smp(2 * ONE, ONE, 32'h0);
    add_smp(W_MIN, 32'h0, W_MAX);
    add_smp(W_MAX, W_MIN, 32'h5555_AAAA);
    // full-scale inner trapezoids push the row sum past 48 bits
    add_cfg(REG_ROW_COUNT, 16'd1);
    add_cfg(REG_FIRST_LEN, 16'd4);
    add_smp(W_MAX, W_MIN, W_MIN);
    add_smp(W_MAX, W_MAX, W_MAX);
    add_smp(W_MIN, W_MAX, 32'h0);
    add_smp(W_MIN, W_MIN, 32'h0, 1'b1, 64'd0, 1'b1);
    // zero lengths: every sample closes an integration
    add_cfg(REG_ROW_COUNT, 16'd0);
    add_cfg(REG_FIRST_LEN, 16'd0);
    add_smp(W_MAX, W_MAX, W_MIN, 1'b1, 64'd0, 1'b0);
    add_smp(W_MIN, W_MIN, W_MAX, 1'b1, 64'd0, 1'b0);
    // clear split mode while the second segment runs; it still ends at its length
    add_cfg(REG_ROW_COUNT, 16'd1);
    add_cfg(REG_FIRST_LEN, 16'd2);
    add_cfg(REG_SECOND_LEN, 16'd3);
    add_cfg(REG_SPLIT_MODE, 16'd1);
    add_smp(ONE, 32'h0, 32'hFFFF_0000);
    add_smp(3 * ONE, ONE, 32'h0);
    add_smp(32'hFFFE_0000, 32'h0004_0000, 32'h0);
    add_cfg(REG_SPLIT_MODE, 16'd0);
    add_smp(ONE, 32'h0005_0000, 32'h0);
    add_smp(ONE, 32'h0006_8000, 32'h0, 1'b1, 64'd0, 1'b0);
    add_cfg(REG_ROW_COUNT, 16'd2);
    add_cfg(REG_FIRST_LEN, 16'd1);
    add_cfg(REG_SECOND_LEN, 16'd2);
    add_cfg(REG_SPLIT_MODE, 16'd1);
    add_smp(ONE, 32'h0, 32'hFFFF_8000);
    add_smp(2 * ONE, ONE, 32'h0);
    add_smp(32'hFFFF_0000, 2 * ONE, 32'h0);
    add_smp(3 * ONE, 32'h0, 32'h0002_4000);
    add_smp(ONE, ONE, 32'h0);
    add_smp(32'hFFFD_0000, 32'h0003_0000, 32'h0);
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 3))
          0: return W_MAX;
          1: return W_MIN;
          2: return 32'h0;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return 32'($urandom_range(0, 32'h001F_FFFF)) - 32'h0010_0000;
    endcase
  endfunction

  function automatic in_t rand_sample();
    in_t s;
    s.integrand   = rand_word();
    s.inner_coord = rand_word();
    s.outer_coord = rand_word();
    return s;
  endfunction

  function automatic logic [15:0] rand_len(int hi);
    case ($urandom_range(0, 19))
      0: return 16'd0;
      1: return CNT_TOP;
      2: return 16'($urandom_range(6, 16));
      default: return 16'($urandom_range(1, hi));
    endcase
  endfunction

  task automatic send_sample(in_t s, bit typed, out_t want);
    out_t res;
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (integrate_sample(s, res))
      expected_totals.push_back(typed ? want : res);
  endtask

  // Hold off until the block has settled, then write one register
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [LEN_W-1:0] val);
    in_valid <= 1'b0;
    while (expected_totals.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_ROW_COUNT:  rows_cfg = val;
      REG_FIRST_LEN:  len1_cfg = val;
      REG_SECOND_LEN: len2_cfg = val;
      REG_SPLIT_MODE: split_cfg = val[0];
      default: ;
    endcase
  endtask

  always @(posedge clk) out_ready <= ($urandom_range(0, 99) >= out_stall_pct);

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_totals.size() == 0) begin
        $error("unexpected transaction: integral %0d, saturated %0b",
               out_data.integral, out_data.saturated);
        mismatches++;
      end else begin
        head_total = expected_totals.pop_front();
        if (out_data.integral !== head_total.integral) begin
          $error("integral: expected %0d, got %0d", head_total.integral, out_data.integral);
          mismatches++;
        end
        if (out_data.saturated !== head_total.saturated) begin
          $error("saturated: expected %0b, got %0b", head_total.saturated,
                 out_data.saturated);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int          sent;
    int          n_items;
    longint      per_row;
    longint      per_run;
    logic [15:0] rc, l1, l2, mode;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    in_idle_pct   = 9;
    out_stall_pct = 85;
    reset_integrator();
    build_directed();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == DIR_CFG)
        write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
      else
        send_sample(dir_rows[i].smp, dir_rows[i].typed, dir_rows[i].want);
    end

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent >= 2 * RANDOM_ITEMS / 3) begin
        in_idle_pct   = 0;
        out_stall_pct = 0;
      end else if (sent >= RANDOM_ITEMS / 3) begin
        in_idle_pct   = 85;
        out_stall_pct = 9;
      end
      rc   = rand_len(4);
      l1   = rand_len(5);
      l2   = rand_len(5);
      mode = 16'($urandom_range(0, 16'hFFFF));
      write_reg(REG_ROW_COUNT, rc);
      write_reg(REG_FIRST_LEN, l1);
      write_reg(REG_SECOND_LEN, l2);
      write_reg(REG_SPLIT_MODE, mode);
      per_row = longint'((l1 == 16'd0) ? 16'd1 : l1);
      if (mode[0])
        per_row += longint'((l2 == 16'd0) ? 16'd1 : l2);
      per_run = longint'((rc == 16'd0) ? 16'd1 : rc) * per_row;
      // long settings get a short partial run; the rest whole integrations, at times with part of another
      if (per_run > 200) begin
        n_items = $urandom_range(3, 40);
      end else begin
        n_items = int'(per_run) * $urandom_range(1, 3);
        if ($urandom_range(0, 4) == 0)
          n_items += $urandom_range(1, int'(per_run));
      end
      repeat (n_items) begin
        send_sample(rand_sample(), 1'b0, '0);
        sent++;
      end
    end

    in_valid <= 1'b0;
    while (expected_totals.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
